/* src/hptf_pkg.sv */
package hptf_pkg;

  localparam int unsigned FIELD_LENGTH_DEF = 10500;
  localparam int unsigned FIELD_WIDTH_DEF  = 6800;
  localparam int unsigned IMG_W            = 1920;
  localparam int unsigned IMG_H            = 1080;

  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned REG_W        = 64;
  localparam int unsigned REGS_PER_CAM = 4;

  localparam logic [1:0] REG_COEF_A = 2'd0;
  localparam logic [1:0] REG_COEF_B = 2'd1;
  localparam logic [1:0] REG_COEF_C = 2'd2;
  localparam logic [1:0] REG_COEF_D = 2'd3;

  localparam logic [REG_W-1:0] COEF_UNITY = 64'd65536;

  localparam int unsigned PIX_W   = 12;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned SUM_W   = 47;
  localparam int unsigned MAG_W   = 46;
  localparam int unsigned QSHIFT  = 14;
  localparam int unsigned NUM_W   = 59;
  localparam int unsigned DEN_W   = 46;
  localparam int unsigned QM_W    = 32;
  localparam int unsigned K_W     = 20;
  localparam int unsigned PROD_W  = QM_W + K_W;
  localparam int unsigned CDEN_W  = 12;

  localparam logic [CDEN_W-1:0] DEN_X = CDEN_W'(2 * IMG_W);
  localparam logic [CDEN_W-1:0] DEN_Y = CDEN_W'(IMG_H);

  localparam int unsigned CLP_W  = 37;
  localparam int unsigned CLP_LO = 18;
  localparam int unsigned RCP_W  = 27;
  localparam int unsigned RQ_W   = 27;
  localparam int unsigned RSUM_W = 64;

  localparam logic [RCP_W-1:0] RCP_X = RCP_W'((64'd1 << CLP_W) / (2 * IMG_W));
  localparam logic [RCP_W-1:0] RCP_Y = RCP_W'((64'd1 << CLP_W) / IMG_H);

  typedef struct packed {
    logic cam;
    logic fault;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage

/* src/hptf_front.sv */
module hptf_front
  import hptf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 cam_i,
  input  logic [PIX_W-1:0]     x_i,
  input  logic [PIX_W-1:0]     y_i,
  input  logic [REG_W-1:0]     coef_i [NUM_REGS],
  output logic                 valid_o,
  output logic [NUM_W-1:0]     numx_o,
  output logic [NUM_W-1:0]     numy_o,
  output logic [DEN_W-1:0]     den_o,
  output side_t                side_o
);

  logic [REG_W-1:0] ra, rb, rc, rd;
  logic signed [31:0] h11, h12, h13, h21, h22, h23, h31, h32;
  logic signed [PIX_W:0] xs, ys;

  logic                v1_q, v2_q, v3_q;
  logic                cam1_q, cam2_q;
  logic signed [44:0]  p11_q, p12_q, p21_q, p22_q, p31_q, p32_q;
  logic signed [31:0]  h13_q, h23_q;
  logic signed [SUM_W-1:0] nx_d, ny_d, d_d;
  logic signed [SUM_W-1:0] nx_q, ny_q, d_q;
  logic [SUM_W-1:0]    mx, my, md;
  logic [NUM_W-1:0]    numx_q, numy_q;
  logic [DEN_W-1:0]    den_q;
  side_t               side_q;

  always_comb begin
    ra = coef_i[{cam_i, REG_COEF_A}];
    rb = coef_i[{cam_i, REG_COEF_B}];
    rc = coef_i[{cam_i, REG_COEF_C}];
    rd = coef_i[{cam_i, REG_COEF_D}];
    h11 = $signed(ra[31:0]);
    h12 = $signed(ra[63:32]);
    h13 = $signed(rb[31:0]);
    h21 = $signed(rb[63:32]);
    h22 = $signed(rc[31:0]);
    h23 = $signed(rc[63:32]);
    h31 = $signed(rd[31:0]);
    h32 = $signed(rd[63:32]);
    xs = $signed({1'b0, x_i});
    ys = $signed({1'b0, y_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cam1_q <= cam_i;
      p11_q  <= 45'(h11) * 45'(xs);
      p12_q  <= 45'(h12) * 45'(ys);
      p21_q  <= 45'(h21) * 45'(xs);
      p22_q  <= 45'(h22) * 45'(ys);
      p31_q  <= 45'(h31) * 45'(xs);
      p32_q  <= 45'(h32) * 45'(ys);
      h13_q  <= h13;
      h23_q  <= h23;
    end
  end

  always_comb begin
    nx_d = SUM_W'(p11_q) + SUM_W'(p12_q) + SUM_W'(h13_q);
    ny_d = SUM_W'(p21_q) + SUM_W'(p22_q) + SUM_W'(h23_q);
    d_d  = SUM_W'(p31_q) + SUM_W'(p32_q) + $signed(SUM_W'(64'd1 << 30));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cam2_q <= cam1_q;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      d_q    <= d_d;
    end
  end

  always_comb begin
    mx = nx_q[SUM_W-1] ? SUM_W'(-nx_q) : SUM_W'(nx_q);
    my = ny_q[SUM_W-1] ? SUM_W'(-ny_q) : SUM_W'(ny_q);
    md = d_q[SUM_W-1]  ? SUM_W'(-d_q)  : SUM_W'(d_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx_q       <= {mx[NUM_W-QSHIFT-1:0], {QSHIFT{1'b0}}};
      numy_q       <= {my[NUM_W-QSHIFT-1:0], {QSHIFT{1'b0}}};
      den_q        <= md[DEN_W-1:0];
      side_q.cam   <= cam2_q;
      side_q.fault <= (d_q == '0);
      side_q.neg_x <= nx_q[SUM_W-1] ^ d_q[SUM_W-1];
      side_q.neg_y <= ny_q[SUM_W-1] ^ d_q[SUM_W-1];
    end
  end

  assign valid_o = v3_q;
  assign numx_o  = numx_q;
  assign numy_o  = numy_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

/* src/hptf_divpipe.sv */
module hptf_divpipe
  import hptf_pkg::*;
#(
  parameter int unsigned NW = NUM_W,
  parameter int unsigned DW = DEN_W,
  parameter int unsigned SW = $bits(side_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          v_s [NW+1];
  logic [NW-1:0] n_s [NW+1];
  logic [DW-1:0] r_s [NW+1];
  logic [DW-1:0] d_s [NW+1];
  logic [SW-1:0] s_s [NW+1];

  assign v_s[0] = valid_i;
  assign n_s[0] = num_i;
  assign r_s[0] = '0;
  assign d_s[0] = den_i;
  assign s_s[0] = side_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_q;
    logic [NW-1:0] n_q, n_d;
    logic [DW-1:0] r_q, r_d, d_q;
    logic [SW-1:0] s_q;
    logic [DW:0]   t, diff;
    logic          ge;

    always_comb begin
      t    = {r_s[k], n_s[k][NW-1]};
      diff = t - {1'b0, d_s[k]};
      ge   = (t >= {1'b0, d_s[k]});
      r_d  = ge ? diff[DW-1:0] : t[DW-1:0];
      n_d  = {n_s[k][NW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q <= n_d;
        r_q <= r_d;
        d_q <= d_s[k];
        s_q <= s_s[k];
      end
    end

    assign v_s[k+1] = v_q;
    assign n_s[k+1] = n_q;
    assign r_s[k+1] = r_q;
    assign d_s[k+1] = d_q;
    assign s_s[k+1] = s_q;
  end

  assign valid_o = v_s[NW];
  assign quot_o  = n_s[NW];
  assign side_o  = s_s[NW];

endmodule

/* src/hptf_scale.sv */
module hptf_scale
  import hptf_pkg::*;
#(
  parameter int unsigned FIELD_LENGTH = FIELD_LENGTH_DEF,
  parameter int unsigned FIELD_WIDTH  = FIELD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NUM_W-1:0]   qx_i,
  input  logic [NUM_W-1:0]   qy_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [OUT_W-1:0]   field_x_o,
  output logic [OUT_W-1:0]   field_y_o,
  output logic               fault_o
);

  localparam logic [K_W-1:0] KX   = K_W'(FIELD_LENGTH * 16);
  localparam logic [K_W-1:0] KY   = K_W'(FIELD_WIDTH * 16);
  localparam logic [K_W-1:0] OFS  = K_W'((FIELD_LENGTH / 2) * 16);
  localparam int unsigned    MH_W = RCP_W + CLP_W - CLP_LO;
  localparam int unsigned    ML_W = RCP_W + CLP_LO;
  localparam int unsigned    RM_W = CLP_W + 2;
  localparam int unsigned    VW   = RQ_W + 3;

  logic [QM_W-1:0]   qmx, qmy;
  logic              vm_q;
  logic [PROD_W-1:0] px_q, py_q;
  side_t             sm_q;

  logic [CLP_W-1:0]  pcx_d, pcy_d;
  logic              vr_q;
  logic [CLP_W-1:0]  pcx_q, pcy_q;
  logic [MH_W-1:0]   mhx_q, mhy_q;
  logic [ML_W-1:0]   mlx_q, mly_q;
  side_t             sr_q;

  logic [RSUM_W-1:0] rsx_d, rsy_d;
  logic              vs_q;
  logic [CLP_W-1:0]  psx_q, psy_q;
  logic [RQ_W-1:0]   q0x_q, q0y_q;
  side_t             ss_q;

  logic [RM_W-1:0]   remx_d, remy_d;
  logic              vt_q;
  logic [RM_W-1:0]   remx_q, remy_q;
  logic [RQ_W-1:0]   qtx_q, qty_q;
  side_t             st_q;

  logic              vc_q;
  logic [RQ_W-1:0]   qcx_q, qcy_q;
  side_t             sc_q;

  logic signed [VW-1:0] vx, vy;
  logic [OUT_W-1:0]  fx_d, fy_d;
  logic              v_q;
  logic [OUT_W-1:0]  fx_q, fy_q;
  logic              fault_q;

  localparam logic signed [VW-1:0] SMAX = VW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [VW-1:0] SMIN = -VW'(64'd1 << (OUT_W - 1));

  always_comb begin
    qmx = (|qx_i[NUM_W-1:QM_W-1]) ? QM_W'(64'd1 << (QM_W - 1)) : qx_i[QM_W-1:0];
    qmy = (|qy_i[NUM_W-1:QM_W-1]) ? QM_W'(64'd1 << (QM_W - 1)) : qy_i[QM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vr_q <= 1'b0;
      vs_q <= 1'b0;
      vt_q <= 1'b0;
      vc_q <= 1'b0;
      v_q  <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
      vr_q <= vm_q;
      vs_q <= vr_q;
      vt_q <= vs_q;
      vc_q <= vt_q;
      v_q  <= vc_q;
    end
  end

  // saturate the product early: any quotient past the clamp saturates anyway
  always_comb begin
    pcx_d  = (|px_q[PROD_W-1:CLP_W]) ? {CLP_W{1'b1}} : px_q[CLP_W-1:0];
    pcy_d  = (|py_q[PROD_W-1:CLP_W]) ? {CLP_W{1'b1}} : py_q[CLP_W-1:0];
    rsx_d  = (RSUM_W'(mhx_q) << CLP_LO) + RSUM_W'(mlx_q);
    rsy_d  = (RSUM_W'(mhy_q) << CLP_LO) + RSUM_W'(mly_q);
    remx_d = RM_W'(psx_q) - RM_W'(q0x_q) * RM_W'(DEN_X);
    remy_d = RM_W'(psy_q) - RM_W'(q0y_q) * RM_W'(DEN_Y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= PROD_W'(qmx) * PROD_W'(KX);
      py_q   <= PROD_W'(qmy) * PROD_W'(KY);
      sm_q   <= side_i;

      pcx_q  <= pcx_d;
      pcy_q  <= pcy_d;
      mhx_q  <= MH_W'(pcx_d[CLP_W-1:CLP_LO]) * MH_W'(RCP_X);
      mlx_q  <= ML_W'(pcx_d[CLP_LO-1:0]) * ML_W'(RCP_X);
      mhy_q  <= MH_W'(pcy_d[CLP_W-1:CLP_LO]) * MH_W'(RCP_Y);
      mly_q  <= ML_W'(pcy_d[CLP_LO-1:0]) * ML_W'(RCP_Y);
      sr_q   <= sm_q;

      psx_q  <= pcx_q;
      psy_q  <= pcy_q;
      q0x_q  <= rsx_d[RSUM_W-1:CLP_W];
      q0y_q  <= rsy_d[RSUM_W-1:CLP_W];
      ss_q   <= sr_q;

      remx_q <= remx_d;
      remy_q <= remy_d;
      qtx_q  <= q0x_q;
      qty_q  <= q0y_q;
      st_q   <= ss_q;

      // estimate is at most one below the quotient
      qcx_q  <= qtx_q + RQ_W'(remx_q >= RM_W'(DEN_X));
      qcy_q  <= qty_q + RQ_W'(remy_q >= RM_W'(DEN_Y));
      sc_q   <= st_q;
    end
  end

  always_comb begin
    vx = $signed({3'b000, qcx_q});
    vy = $signed({3'b000, qcy_q});
    if (sc_q.neg_x) begin
      vx = -vx;
    end
    if (sc_q.neg_y) begin
      vy = -vy;
    end
    if (sc_q.cam) begin
      vx = vx + $signed(VW'(OFS));
    end
    priority if (vx > SMAX) begin
      fx_d = SMAX[OUT_W-1:0];
    end else if (vx < SMIN) begin
      fx_d = SMIN[OUT_W-1:0];
    end else begin
      fx_d = vx[OUT_W-1:0];
    end
    priority if (vy > SMAX) begin
      fy_d = SMAX[OUT_W-1:0];
    end else if (vy < SMIN) begin
      fy_d = SMIN[OUT_W-1:0];
    end else begin
      fy_d = vy[OUT_W-1:0];
    end
    if (sc_q.fault) begin
      fx_d = '0;
      fy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q    <= fx_d;
      fy_q    <= fy_d;
      fault_q <= sc_q.fault;
    end
  end

  assign valid_o   = v_q;
  assign field_x_o = fx_q;
  assign field_y_o = fy_q;
  assign fault_o   = fault_q;

endmodule

/* src/homography_point_to_field.sv */
// Maps a camera pixel (pixel_x, pixel_y) to global field coordinates in units of 1/16
// through the selected camera's homography (eight 64-bit coefficient registers, written
// over the cfg port). The user must write them while no transaction is in flight, which
// is not enforced. Fully pipelined: one point per cycle unless stalled, via 3 front
// stages, two 59-stage bit-per-stage projective dividers and 6 scale stages (constant
// division by reciprocal multiply and a compare-and-adjust step). The whole pipeline
// holds while a result waits. A zero denominator sets divide_fault and returns zero.
module homography_point_to_field
  import hptf_pkg::*;
#(
  parameter int unsigned FIELD_LENGTH = FIELD_LENGTH_DEF,
  parameter int unsigned FIELD_WIDTH  = FIELD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 camera_select_i,
  input  logic [PIX_W-1:0]     pixel_x_i,
  input  logic [PIX_W-1:0]     pixel_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     field_x_o,
  output logic [OUT_W-1:0]     field_y_o,
  output logic                 divide_fault_o
);

  logic [REG_W-1:0] coef_q [NUM_REGS];
  logic             en;

  logic             fv;
  logic [NUM_W-1:0] numx, numy, qx, qy;
  logic [DEN_W-1:0] den;
  side_t            fside, dside;
  logic [$bits(side_t)-1:0] dside_raw, dside_y_raw;
  logic             dv, dvy;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i % REGS_PER_CAM == int'(REG_COEF_A) || i % REGS_PER_CAM == int'(REG_COEF_C)) begin
          coef_q[i] <= COEF_UNITY;
        end else begin
          coef_q[i] <= '0;
        end
      end
    end else if (cfg_valid_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  hptf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cam_i   (camera_select_i),
    .x_i     (pixel_x_i),
    .y_i     (pixel_y_i),
    .coef_i  (coef_q),
    .valid_o (fv),
    .numx_o  (numx),
    .numy_o  (numy),
    .den_o   (den),
    .side_o  (fside)
  );

  hptf_divpipe #(
    .NW (NUM_W),
    .DW (DEN_W),
    .SW ($bits(side_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_i   (numx),
    .den_i   (den),
    .side_i  (fside),
    .valid_o (dv),
    .quot_o  (qx),
    .side_o  (dside_raw)
  );

  hptf_divpipe #(
    .NW (NUM_W),
    .DW (DEN_W),
    .SW ($bits(side_t))
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_i   (numy),
    .den_i   (den),
    .side_i  (fside),
    .valid_o (dvy),
    .quot_o  (qy),
    .side_o  (dside_y_raw)
  );

  always_comb begin
    dside       = side_t'(dside_raw);
    dside.neg_y = dside_y_raw[0];
  end

  hptf_scale #(
    .FIELD_LENGTH (FIELD_LENGTH),
    .FIELD_WIDTH  (FIELD_WIDTH)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (dv & dvy),
    .qx_i      (qx),
    .qy_i      (qy),
    .side_i    (dside),
    .valid_o   (out_valid_o),
    .field_x_o (field_x_o),
    .field_y_o (field_y_o),
    .fault_o   (divide_fault_o)
  );

endmodule

/* sim/homography_point_to_field_tb.sv */
`timescale 1ns / 1ps

module homography_point_to_field_tb;
  import hptf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LATENCY_WAIT = 160;

  typedef struct packed {
    logic [OUT_W-1:0] field_x;
    logic [OUT_W-1:0] field_y;
    logic             fault;
  } field_point_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 camera_select_i;
  logic [PIX_W-1:0]     pixel_x_i;
  logic [PIX_W-1:0]     pixel_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [OUT_W-1:0]     field_x_o;
  logic [OUT_W-1:0]     field_y_o;
  logic                 divide_fault_o;

  logic [REG_W-1:0] coef_regs [NUM_REGS];
  field_point_t     pending_points [$];
  int unsigned      error_count;
  int unsigned      cycle_count;
  bit               idle_enable;

  homography_point_to_field dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .camera_select_i(camera_select_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .field_x_o      (field_x_o),
    .field_y_o      (field_y_o),
    .divide_fault_o (divide_fault_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint half_signed(logic [31:0] h);
    return longint'($signed(h));
  endfunction

  function automatic longint sat_field(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint clamp_quot(longint q);
    longint lim;
    lim = longint'(1) <<< 40;
    if (q > lim) return lim;
    if (q < -lim) return -lim;
    return q;
  endfunction

  function automatic field_point_t project_point(logic cam, logic [PIX_W-1:0] px,
                                                 logic [PIX_W-1:0] py);
    field_point_t res;
    logic [REG_W-1:0] ra, rb, rc, rd;
    longint x, y, nx, ny, den, qx, qy, fx, fy;
    int unsigned base;
    base = cam * REGS_PER_CAM;
    ra = coef_regs[base + REG_COEF_A];
    rb = coef_regs[base + REG_COEF_B];
    rc = coef_regs[base + REG_COEF_C];
    rd = coef_regs[base + REG_COEF_D];
    x = longint'({52'd0, px});
    y = longint'({52'd0, py});
    nx = half_signed(ra[31:0]) * x + half_signed(ra[63:32]) * y + half_signed(rb[31:0]);
    ny = half_signed(rb[63:32]) * x + half_signed(rc[31:0]) * y + half_signed(rc[63:32]);
    den = half_signed(rd[31:0]) * x + half_signed(rd[63:32]) * y + (longint'(1) <<< 30);
    if (den == 0) begin
      res.field_x = '0;
      res.field_y = '0;
      res.fault = 1'b1;
      return res;
    end
    qx = clamp_quot((nx * 16384) / den);
    qy = clamp_quot((ny * 16384) / den);
    fx = (qx * longint'(FIELD_LENGTH_DEF) * 16) / (2 * longint'(IMG_W));
    fy = (qy * longint'(FIELD_WIDTH_DEF) * 16) / longint'(IMG_H);
    if (cam) fx = fx + (longint'(FIELD_LENGTH_DEF) / 2) * 16;
    fx = sat_field(fx);
    fy = sat_field(fy);
    res.field_x = fx[OUT_W-1:0];
    res.field_y = fy[OUT_W-1:0];
    res.fault = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    field_point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected transaction", field_x_o, 0);
      end else begin
        want = pending_points.pop_front();
        if (field_x_o !== want.field_x) report_mismatch("field_x", field_x_o, want.field_x);
        if (field_y_o !== want.field_y) report_mismatch("field_y", field_y_o, want.field_y);
        if (divide_fault_o !== want.fault)
          report_mismatch("divide_fault", divide_fault_o, want.fault);
      end
    end
  end

  // result backpressure
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  task automatic send_point(logic cam, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    camera_select_i = cam;
    pixel_x_i = px;
    pixel_y_i = py;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(project_point(cam, px, py));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [REG_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i = idx[REG_IDX_W-1:0];
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    coef_regs[idx] = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_camera(int unsigned cam, logic [31:0] h11, logic [31:0] h12,
                            logic [31:0] h13, logic [31:0] h21, logic [31:0] h22,
                            logic [31:0] h23, logic [31:0] h31, logic [31:0] h32);
    wait_drained();
    write_reg(cam * REGS_PER_CAM + REG_COEF_A, {h12, h11});
    write_reg(cam * REGS_PER_CAM + REG_COEF_B, {h21, h13});
    write_reg(cam * REGS_PER_CAM + REG_COEF_C, {h23, h22});
    write_reg(cam * REGS_PER_CAM + REG_COEF_D, {h32, h31});
  endtask

  task automatic send_random_point();
    send_point(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom));
  endtask

  task automatic test_reset_identity();
    send_point(1'b0, 12'd0, 12'd0);
    send_point(1'b1, 12'd0, 12'd0);
    send_point(1'b0, 12'd4095, 12'd4095);
    send_point(1'b1, 12'd4095, 12'd4095);
    send_point(1'b0, 12'd1920, 12'd1080);
    send_point(1'b1, 12'd960, 12'd540);
  endtask

  task automatic test_zero_denominator();
    set_camera(0, 32'h10000, 0, 0, 0, 32'h10000, 0, -32'sd1048576, -32'sd524288);
    send_point(1'b0, 12'd1024, 12'd0);
    send_point(1'b0, 12'd0, 12'd2048);
    send_point(1'b0, 12'd512, 12'd1024);
    send_point(1'b0, 12'd1023, 12'd0);
    set_camera(1, 32'h10000, 0, 0, 0, 32'h10000, 0, -32'sd1048576, 0);
    send_point(1'b1, 12'd1024, 12'd7);
  endtask

  task automatic test_saturation();
    // tiny denominator pushes the quotient past the clamp
    set_camera(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h80000000, -32'sd1073741823, 0);
    set_camera(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff, 0, -32'sd1073741823);
    send_point(1'b0, 12'd1, 12'd0);
    send_point(1'b1, 12'd0, 12'd1);
    send_point(1'b0, 12'd4095, 12'd4095);
    send_point(1'b1, 12'd4095, 12'd4095);
    set_camera(0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    set_camera(1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_point(1'b0, 12'd4095, 12'd0);
    send_point(1'b0, 12'd0, 12'd4095);
    send_point(1'b1, 12'd4095, 12'd4095);
    send_point(1'b1, 12'd0, 12'd0);
  endtask

  task automatic randomize_camera(int unsigned cam, bit wild);
    logic [31:0] h [8];
    for (int i = 0; i < 6; i++) begin
      if (wild) h[i] = $urandom;
      else h[i] = 32'($signed($urandom_range(0, 262144)) - 131072);
    end
    for (int i = 6; i < 8; i++) begin
      if (wild) h[i] = $urandom;
      else h[i] = 32'($signed($urandom_range(0, 400000)) - 200000);
    end
    if (!wild) begin
      h[2] = 32'($signed($urandom_range(0, 32'h4000000)) - 32'sh2000000);
      h[5] = 32'($signed($urandom_range(0, 32'h4000000)) - 32'sh2000000);
    end
    set_camera(cam, h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]);
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      randomize_camera(0, phase[0]);
      randomize_camera(1, phase[1]);
      for (int n = 0; n < 65; n++) begin
        send_random_point();
        if (phase == 2 && n == 30) wait_drained();
      end
    end
  endtask

  task automatic test_full_rate();
    idle_enable = 1'b0;
    randomize_camera(0, 1'b0);
    randomize_camera(1, 1'b1);
    for (int n = 0; n < 50; n++) send_random_point();
  endtask

  initial begin
    int unsigned settle;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    camera_select_i = 1'b0;
    pixel_x_i = '0;
    pixel_y_i = '0;
    error_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    for (int i = 0; i < NUM_REGS; i++) coef_regs[i] = '0;
    coef_regs[REG_COEF_A] = COEF_UNITY;
    coef_regs[REG_COEF_C] = COEF_UNITY;
    coef_regs[REGS_PER_CAM + REG_COEF_A] = COEF_UNITY;
    coef_regs[REGS_PER_CAM + REG_COEF_C] = COEF_UNITY;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_identity();
    test_zero_denominator();
    test_saturation();
    test_random_phases();
    test_full_rate();

    wait_drained();
    settle = 0;
    while (settle < LATENCY_WAIT) begin
      @(posedge clk_i);
      settle++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/hptf_pkg.sv
src/hptf_front.sv
src/hptf_divpipe.sv
src/hptf_scale.sv
src/homography_point_to_field.sv
sim/homography_point_to_field_tb.sv
